// ===== rtl/clmd_pkg.sv =====
// ----------------------------------------------------------------------------
// clmd_pkg
// Shared constants, types and character tables for the Content-Length
// message deframer.
// ----------------------------------------------------------------------------
package clmd_pkg;

  // Width of the message length value; lengths saturate at 2^LENGTH_BITS - 1.
  localparam int LENGTH_BITS = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_KEY0  = 8'h43;  // 'C', first keyword character

  // Progress through the value that follows the keyword.
  typedef enum logic [2:0] {
    PH_KEYWORD,
    PH_BLANKS,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Request from the header parser to open a body.
  typedef struct packed {
    logic                   start;
    logic [LENGTH_BITS-1:0] length;
  } body_start_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_of_message;
    logic       last_of_message;
  } result_t;

  // The text "Content-Length: ", one character per index.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;  // C
      4'd1:    c = 8'h6F;  // o
      4'd2:    c = 8'h6E;  // n
      4'd3:    c = 8'h74;  // t
      4'd4:    c = 8'h65;  // e
      4'd5:    c = 8'h6E;  // n
      4'd6:    c = 8'h74;  // t
      4'd7:    c = 8'h2D;  // -
      4'd8:    c = 8'h4C;  // L
      4'd9:    c = 8'h65;  // e
      4'd10:   c = 8'h6E;  // n
      4'd11:   c = 8'h67;  // g
      4'd12:   c = 8'h74;  // t
      4'd13:   c = 8'h68;  // h
      4'd14:   c = 8'h3A;  // :
      default: c = 8'h20;  // space
    endcase
    return c;
  endfunction

  // The header terminator CR LF CR LF.
  function automatic logic [7:0] term_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx[0])
      1'b0:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/clmd_hdr_parse.sv =====
// ----------------------------------------------------------------------------
// clmd_hdr_parse
// Header phase: keyword search, length value parsing and terminator search.
// ----------------------------------------------------------------------------
module clmd_hdr_parse import clmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  data_byte,
  output body_start_t body_start
);

  logic [1:0]             term_prog_r, term_prog_nxt;
  logic [3:0]             key_prog_r, key_prog_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [LENGTH_BITS+3:0] acc_ext;
  logic [LENGTH_BITS+3:0] acc_x10;
  logic [LENGTH_BITS-1:0] acc_step;
  logic                   term_hit;
  logic                   term_done;

  // Decimal step acc * 10 + d, saturating when it leaves LENGTH_BITS.
  always_comb begin
    is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    digit_val = 4'(data_byte - CH_ZERO);
    acc_ext   = {4'b0, acc_r};
    acc_x10   = (acc_ext << 3) + (acc_ext << 1) + {LENGTH_BITS'(0), digit_val};
    if (acc_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) begin
      acc_step = '1;
    end else begin
      acc_step = acc_x10[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    key_prog_nxt  = key_prog_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    term_prog_nxt = term_prog_r;
    body_start    = '0;

    case (phase_r)
      PH_KEYWORD: begin
        if (data_byte == key_char(key_prog_r)) begin
          if (key_prog_r == 4'hF) begin
            key_prog_nxt = '0;
            phase_nxt    = PH_BLANKS;
          end else begin
            key_prog_nxt = key_prog_r + 4'd1;
          end
        end else begin
          key_prog_nxt = {3'b0, data_byte == CH_KEY0};
        end
      end
      PH_BLANKS: begin
        if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
          phase_nxt = PH_BLANKS;
        end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
          neg_nxt   = (data_byte == CH_MINUS);
          phase_nxt = PH_SIGN;
        end else if (is_digit) begin
          acc_nxt   = acc_step;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          acc_nxt   = acc_step;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    term_hit  = (data_byte == term_char(term_prog_r));
    term_done = term_hit && (term_prog_r == 2'd3);
    if (term_hit) begin
      term_prog_nxt = term_prog_r + 2'd1;
    end else begin
      term_prog_nxt = {1'b0, data_byte == CH_CR};
    end

    if (term_done) begin
      body_start.start  = byte_en && (phase_nxt != PH_KEYWORD) && !neg_nxt &&
                          (acc_nxt != '0);
      body_start.length = acc_nxt;
      term_prog_nxt     = '0;
      key_prog_nxt      = '0;
      phase_nxt         = PH_KEYWORD;
      acc_nxt           = '0;
      neg_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_prog_r <= '0;
      key_prog_r  <= '0;
      phase_r     <= PH_KEYWORD;
      acc_r       <= '0;
      neg_r       <= 1'b0;
    end else if (byte_en) begin
      term_prog_r <= term_prog_nxt;
      key_prog_r  <= key_prog_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
    end
  end

endmodule

// ===== rtl/clmd_body_ctr.sv =====
// ----------------------------------------------------------------------------
// clmd_body_ctr
// Body phase: passes the body bytes through and counts them down.
// ----------------------------------------------------------------------------
module clmd_body_ctr import clmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  body_start_t body_start,
  output logic        in_body,
  output logic        res_valid,
  output result_t     res
);

  logic                   in_body_r, in_body_nxt;
  logic                   started_r, started_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic                   at_last;

  assign in_body = in_body_r;
  assign at_last = (remain_r[LENGTH_BITS-1:1] == '0);

  always_comb begin
    in_body_nxt = in_body_r;
    started_nxt = started_r;
    remain_nxt  = remain_r;
    res_valid   = accept && in_body_r;
    res.body_byte        = data_byte;
    res.first_of_message = !started_r;
    res.last_of_message  = at_last;

    if (accept && in_body_r) begin
      if (at_last) begin
        in_body_nxt = 1'b0;
        started_nxt = 1'b0;
        remain_nxt  = '0;
      end else begin
        started_nxt = 1'b1;
        remain_nxt  = remain_r - LENGTH_BITS'(1);
      end
    end else if (body_start.start) begin
      in_body_nxt = 1'b1;
      started_nxt = 1'b0;
      remain_nxt  = body_start.length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      started_r <= 1'b0;
      remain_r  <= '0;
    end else begin
      in_body_r <= in_body_nxt;
      started_r <= started_nxt;
      remain_r  <= remain_nxt;
    end
  end

  // A body always has bytes left to deliver.
  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (remain_r != '0))
    else $error("body phase with no bytes remaining");

  // The last byte of a body returns the block to the header phase.
  a_last_ends_body: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_of_message) |=> !in_body_r)
    else $error("body phase continued after its last byte");

  // A new body opens only from the header phase, and opens fresh.
  a_start_from_header: assert property (@(posedge clk) disable iff (!rst_n)
    body_start.start |-> !in_body_r)
    else $error("body start requested during a body");

  a_start_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    body_start.start |=> (in_body_r && !started_r))
    else $error("body did not open cleanly after its header");

endmodule

// ===== rtl/clmd_out_reg.sv =====
// ----------------------------------------------------------------------------
// clmd_out_reg
// Result register between the deframing logic and the output channel.
// ----------------------------------------------------------------------------
module clmd_out_reg import clmd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Room for a new transaction when the register is empty or the held one leaves this cycle.
  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/content_length_message_deframer_top.sv =====
// ----------------------------------------------------------------------------
// content_length_message_deframer_top
// Cuts a byte stream into message bodies framed by Content-Length headers.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and, when the output side keeps
// up, sustains one input transaction every cycle; results appear in the cycle
// after the byte that causes them, from a single output register. Input is
// held off only while that register holds a result that the output side has
// not yet taken. In the header phase no results are produced: the block looks
// for the first "Content-Length: " keyword, reads the decimal value after it
// (blanks, optional sign, digits, saturating at 2^32 - 1) and watches for the
// CR LF CR LF terminator. A header with no keyword, or with a value that is
// zero or negative, is discarded at its terminator. Otherwise the following
// bytes, as many as the value says, are passed out as the body, with the
// first and last bytes flagged, after which a new header is expected.
// ----------------------------------------------------------------------------
module content_length_message_deframer_top import clmd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_body_byte,
  output logic       out_first_of_message,
  output logic       out_last_of_message
);

  logic        accept;
  logic        in_body;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  body_start_t body_start;

  // A byte is taken whenever the result register can make room for it.
  assign accept = in_valid && in_ready;

  // Header bytes go to the parser; body bytes go to the counter, which
  // produces the result transactions.
  clmd_hdr_parse u_hdr_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (accept && !in_body),
    .data_byte  (in_data_byte),
    .body_start (body_start)
  );

  clmd_body_ctr u_body_ctr (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .body_start (body_start),
    .in_body    (in_body),
    .res_valid  (res_valid),
    .res        (res)
  );

  // The result register decouples the output handshake from the input, so
  // a new byte can be accepted in the same cycle as a result leaves.
  clmd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_body_byte        = out_res.body_byte;
  assign out_first_of_message = out_res.first_of_message;
  assign out_last_of_message  = out_res.last_of_message;

endmodule
